FILE: design/fta_pkg.sv
// shared widths, reset values and register indexes for the frame timer
package fta_pkg;

	localparam int TS_W           = 32;
	localparam int RATE_W         = 16;
	localparam int TICKS_W        = 34;
	localparam int CFG_IDX_W      = 1;
	localparam int FIFO_DEPTH_DEF = 64;

	typedef logic [TS_W-1:0]      ts_t;
	typedef logic [RATE_W-1:0]    rate_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_TICKS_PER_SECOND  = 1'd0;
	localparam cfg_idx_t CFG_LOCK_PERIOD_TICKS = 1'd1;

	localparam ts_t TPS_RESET  = 32'd1000;
	localparam ts_t LOCK_RESET = 32'd0;

	localparam rate_t FRAMES_SAT = 16'hFFFF;

endpackage

FILE: design/fta_if.sv
// valid/ready channels: timestamp in, result out, register write
interface fta_in_if;
	logic           valid;
	logic           ready;
	fta_pkg::ts_t   timestamp;

	modport source (output valid, output timestamp, input ready);
	modport sink   (input valid, input timestamp, output ready);
endinterface

interface fta_out_if #(
	parameter int CNT_W = 7
);
	logic                 valid;
	logic                 ready;
	fta_pkg::ts_t         frame_delta;
	fta_pkg::ts_t         average_delta;
	fta_pkg::rate_t       frame_rate;
	logic                 sample_accepted;
	logic                 rate_updated;
	logic [CNT_W-1:0]     stored_samples;

	modport source (output valid, output frame_delta, output average_delta, output frame_rate,
		output sample_accepted, output rate_updated, output stored_samples, input ready);
	modport sink   (input valid, input frame_delta, input average_delta, input frame_rate,
		input sample_accepted, input rate_updated, input stored_samples, output ready);
endinterface

interface fta_cfg_if;
	logic               valid;
	logic               ready;
	fta_pkg::cfg_idx_t  index;
	fta_pkg::ts_t       data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/fta_alu.sv
// shared add/subtract unit, carry out doubles as unsigned a >= b on subtract
module fta_alu #(
	parameter int W = 39
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] sum,
	output logic         carry
);

	logic [W-1:0] b_op;

	assign b_op = sub ? ~b : b;
	assign {carry, sum} = {1'b0, a} + {1'b0, b_op} + {{W{1'b0}}, sub};

endmodule

FILE: design/fta_fifo.sv
// delta sample memory, one write and one registered read port
module fta_fifo #(
	parameter int DEPTH = 64,
	parameter int PTR_W = 6
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [PTR_W-1:0]   wr_addr,
	input  fta_pkg::ts_t       wr_data,
	input  logic               rd_en,
	input  logic [PTR_W-1:0]   rd_addr,
	output fta_pkg::ts_t       rd_data
);

	fta_pkg::ts_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: design/frame_timer_average_fps.sv
// frame timer top: one item at a time through a shared add/subtract unit and serial divider
// the divide is skipped when the fifo is empty; dropped and base beats give no result
// a new beat is taken only once the previous one has been handed over or dropped, later while
// the result register is stalled; reset: arst_n clears all registers at once, no clearing pass,
// but the sample memory is not reset; ticks_per_second comes up as 1000 and lock_period_ticks
// as 0; memory reads made before the fifo is full are discarded
module frame_timer_average_fps #(
	parameter int FIFO_DEPTH = fta_pkg::FIFO_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	fta_in_if.sink    ts_ch,
	fta_out_if.source res_ch,
	fta_cfg_if.sink   cfg_ch
);

	localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
	localparam int PTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int SUM_W     = fta_pkg::TS_W + $clog2(FIFO_DEPTH);
	localparam int ALU_W     = ((SUM_W > fta_pkg::TICKS_W) ? SUM_W : fta_pkg::TICKS_W) + 1;
	localparam int DIV_CNT_W = $clog2(SUM_W + 1);
	localparam int TW        = fta_pkg::TICKS_W;

	// sequencer codes
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DELTA  = 4'd1;
	localparam logic [3:0] S_LOCK   = 4'd2;
	localparam logic [3:0] S_DIFF1  = 4'd3;
	localparam logic [3:0] S_DIFF2  = 4'd4;
	localparam logic [3:0] S_THR    = 4'd5;
	localparam logic [3:0] S_SUBOLD = 4'd6;
	localparam logic [3:0] S_ADDNEW = 4'd7;
	localparam logic [3:0] S_WIN    = 4'd8;
	localparam logic [3:0] S_WCMP   = 4'd9;
	localparam logic [3:0] S_DIV    = 4'd10;
	localparam logic [3:0] S_OUT    = 4'd11;

	logic [3:0]            state_q;

	// configuration
	fta_pkg::ts_t          tps_q;
	fta_pkg::ts_t          lock_q;

	// per-frame working registers
	fta_pkg::ts_t          ts_q;
	fta_pkg::ts_t          last_q;
	logic                  base_valid_q;
	fta_pkg::ts_t          delta_q;
	fta_pkg::ts_t          diff_q;
	logic                  acc_q;
	logic                  upd_q;

	// running statistics
	logic [SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [PTR_W-1:0]      wr_ptr_q;
	fta_pkg::ts_t          avg_q;
	fta_pkg::rate_t        frames_q;
	logic [TW-1:0]         wt_q;
	fta_pkg::rate_t        rate_q;

	// serial divider
	logic [CNT_W-1:0]      rem_q;
	logic [SUM_W-1:0]      dq_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic [CNT_W:0]        rem_shift;
	logic [SUM_W-1:0]      dq_next;

	// result register
	logic                  res_valid_q;
	fta_pkg::ts_t          res_delta_q;
	fta_pkg::ts_t          res_avg_q;
	fta_pkg::rate_t        res_rate_q;
	logic                  res_acc_q;
	logic                  res_upd_q;
	logic [CNT_W-1:0]      res_cnt_q;
	logic                  res_load;

	// shared unit hookup
	logic [ALU_W-1:0]      alu_a;
	logic [ALU_W-1:0]      alu_b;
	logic                  alu_sub;
	logic [ALU_W-1:0]      alu_sum;
	logic                  alu_carry;

	// sample memory hookup
	logic                  fifo_wr;
	logic                  fifo_rd;
	fta_pkg::ts_t          fifo_rd_data;

	logic                  cnt_full;
	logic                  in_beat;

	assign in_beat  = ts_ch.valid && ts_ch.ready;
	assign cnt_full = (cnt_q == CNT_W'(FIFO_DEPTH));

	assign ts_ch.ready  = (state_q == S_IDLE);
	assign cfg_ch.ready = 1'b1;

	// handover when the result register is empty or being drained this cycle
	assign res_load = (state_q == S_OUT) && (!res_valid_q || res_ch.ready);

	assign res_ch.valid           = res_valid_q;
	assign res_ch.frame_delta     = res_delta_q;
	assign res_ch.average_delta   = res_avg_q;
	assign res_ch.frame_rate      = res_rate_q;
	assign res_ch.sample_accepted = res_acc_q;
	assign res_ch.rate_updated    = res_upd_q;
	assign res_ch.stored_samples  = res_cnt_q;

	// divider step: bring down the next dividend bit, trial subtract the count
	assign rem_shift = {rem_q, dq_q[SUM_W-1]};
	assign dq_next   = {dq_q[SUM_W-2:0], alu_carry};

	// operand select for the shared unit; on subtract carry high means a >= b
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b1;
		case (state_q)
			S_DELTA: begin
				alu_a = ALU_W'(ts_q);
				alu_b = ALU_W'(last_q);
			end
			S_LOCK: begin
				alu_a = ALU_W'(delta_q);
				alu_b = ALU_W'(lock_q);
			end
			S_DIFF1: begin
				alu_a = ALU_W'(delta_q);
				alu_b = ALU_W'(avg_q);
			end
			S_DIFF2: begin
				alu_a = ALU_W'(avg_q);
				alu_b = ALU_W'(delta_q);
			end
			S_THR: begin
				alu_a = ALU_W'(diff_q);
				alu_b = ALU_W'(tps_q);
			end
			S_SUBOLD: begin
				alu_a = ALU_W'(sum_q);
				alu_b = ALU_W'(fifo_rd_data);
			end
			S_ADDNEW: begin
				alu_a   = ALU_W'(sum_q);
				alu_b   = ALU_W'(delta_q);
				alu_sub = 1'b0;
			end
			S_WIN: begin
				alu_a   = ALU_W'(wt_q);
				alu_b   = ALU_W'(delta_q);
				alu_sub = 1'b0;
			end
			S_WCMP: begin
				alu_a = ALU_W'(tps_q);
				alu_b = ALU_W'(wt_q);
			end
			S_DIV: begin
				alu_a = ALU_W'(rem_shift);
				alu_b = ALU_W'(cnt_q);
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	fta_alu #(
		.W (ALU_W)
	) u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.sub   (alu_sub),
		.sum   (alu_sum),
		.carry (alu_carry)
	);

	// oldest sample is fetched in S_THR when the filter passes, new one written in S_ADDNEW after S_SUBOLD
	assign fifo_rd = (state_q == S_THR) && alu_carry == 1'b0;
	assign fifo_wr = (state_q == S_ADDNEW);

	fta_fifo #(
		.DEPTH (FIFO_DEPTH),
		.PTR_W (PTR_W)
	) u_fifo (
		.clk     (clk),
		.wr_en   (fifo_wr),
		.wr_addr (wr_ptr_q),
		.wr_data (delta_q),
		.rd_en   (fifo_rd),
		.rd_addr (wr_ptr_q),
		.rd_data (fifo_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			tps_q        <= fta_pkg::TPS_RESET;
			lock_q       <= fta_pkg::LOCK_RESET;
			ts_q         <= '0;
			last_q       <= '0;
			base_valid_q <= 1'b0;
			delta_q      <= '0;
			diff_q       <= '0;
			acc_q        <= 1'b0;
			upd_q        <= 1'b0;
			sum_q        <= '0;
			cnt_q        <= '0;
			wr_ptr_q     <= '0;
			avg_q        <= '0;
			frames_q     <= '0;
			wt_q         <= '0;
			rate_q       <= '0;
			rem_q        <= '0;
			dq_q         <= '0;
			div_cnt_q    <= '0;
			res_valid_q  <= 1'b0;
			res_delta_q  <= '0;
			res_avg_q    <= '0;
			res_rate_q   <= '0;
			res_acc_q    <= 1'b0;
			res_upd_q    <= 1'b0;
			res_cnt_q    <= '0;
		end else begin
			// register writes: to be issued only while idle; the block itself does not enforce it
			if (cfg_ch.valid) begin
				case (cfg_ch.index)
					fta_pkg::CFG_TICKS_PER_SECOND:  tps_q  <= cfg_ch.data;
					fta_pkg::CFG_LOCK_PERIOD_TICKS: lock_q <= cfg_ch.data;
					default: begin
						tps_q <= tps_q;
					end
				endcase
			end

			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						if (!base_valid_q) begin
							// first beat only sets the base
							last_q       <= ts_ch.timestamp;
							base_valid_q <= 1'b1;
						end else begin
							ts_q    <= ts_ch.timestamp;
							state_q <= S_DELTA;
						end
					end
				end
				S_DELTA: begin
					delta_q <= alu_sum[fta_pkg::TS_W-1:0];
					state_q <= S_LOCK;
				end
				S_LOCK: begin
					// locked drop keeps the old base
					if (lock_q != '0 && !alu_carry) begin
						state_q <= S_IDLE;
					end else begin
						last_q  <= ts_q;
						state_q <= S_DIFF1;
					end
				end
				S_DIFF1: begin
					diff_q  <= alu_sum[fta_pkg::TS_W-1:0];
					state_q <= alu_carry ? S_THR : S_DIFF2;
				end
				S_DIFF2: begin
					diff_q  <= alu_sum[fta_pkg::TS_W-1:0];
					state_q <= S_THR;
				end
				S_THR: begin
					// outlier filter: diff below one second of ticks
					acc_q   <= !alu_carry;
					state_q <= alu_carry ? S_WIN : S_SUBOLD;
				end
				S_SUBOLD: begin
					if (cnt_full) begin
						sum_q <= alu_sum[SUM_W-1:0];
					end
					state_q <= S_ADDNEW;
				end
				S_ADDNEW: begin
					sum_q    <= alu_sum[SUM_W-1:0];
					wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
					if (!cnt_full) begin
						cnt_q <= cnt_q + 1'b1;
					end
					state_q  <= S_WIN;
				end
				S_WIN: begin
					if (frames_q != fta_pkg::FRAMES_SAT) begin
						frames_q <= frames_q + 1'b1;
					end
					// window length saturates
					wt_q    <= (|alu_sum[ALU_W-1:TW]) ? {TW{1'b1}} : alu_sum[TW-1:0];
					state_q <= S_WCMP;
				end
				S_WCMP: begin
					// carry low: window went past one second
					upd_q <= !alu_carry;
					if (!alu_carry) begin
						rate_q   <= frames_q;
						frames_q <= '0;
						wt_q     <= '0;
					end
					if (cnt_q == '0) begin
						avg_q   <= '0;
						state_q <= S_OUT;
					end else begin
						rem_q     <= '0;
						dq_q      <= sum_q;
						div_cnt_q <= DIV_CNT_W'(SUM_W);
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q     <= alu_carry ? alu_sum[CNT_W-1:0] : rem_shift[CNT_W-1:0];
					dq_q      <= dq_next;
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == DIV_CNT_W'(1)) begin
						avg_q   <= dq_next[fta_pkg::TS_W-1:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hand over once the result register is free
					if (res_load) begin
						res_delta_q <= delta_q;
						res_avg_q   <= avg_q;
						res_rate_q  <= rate_q;
						res_acc_q   <= acc_q;
						res_upd_q   <= upd_q;
						res_cnt_q   <= cnt_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// sample count never passes the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("sample count above fifo depth");

	// an empty fifo holds no sum
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (sum_q == '0))
		else $error("nonzero sum with empty fifo");

	// a result beat only comes out of the handover step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == S_OUT))
		else $error("result raised outside handover");

	// divider never runs with an exhausted step count
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_cnt_q != '0))
		else $error("divider step count ran out");
`endif

endmodule
